// ===== rtl/bss_pkg.sv =====
package bss_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned DataW = 32;
  localparam int unsigned ModeW = 2;
  localparam int unsigned StatW = 3;

  localparam logic [ModeW-1:0] MODE_ADD    = 2'd0;
  localparam logic [ModeW-1:0] MODE_REMOVE = 2'd1;

  typedef enum logic [StatW-1:0] {
    STAT_ADDED   = 3'd0,
    STAT_DUP     = 3'd1,
    STAT_FULL    = 3'd2,
    STAT_REMOVED = 3'd3,
    STAT_ABSENT  = 3'd4,
    STAT_QUERY   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

// ===== rtl/bounded_set_store_core.sv =====
// Bounded set of up to 16 signed 32-bit values kept packed in a small single-port-read RAM.
// A request is taken when start is high and busy is low; its result (status, presence
// flag, count after the request) appears on the result ports for exactly one cycle with
// done_o high, and must be captured then since the receiver cannot stall the block. A
// request scans the held entries one per cycle through one comparator, stopping at the
// first match, and a remove then moves each later entry down one slot per cycle through
// the same RAM port. A request that finds no match reads every held entry before its
// result (an empty set skips the scan); an add or query stops at the matching slot, and
// a remove that hits reads on through the later entries to move them down. A new
// request may be started in the cycle its predecessor's result is shown. The capacity
// register may be written only while the block is idle; values above 16 act as 16.
module bounded_set_store_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [bss_pkg::ModeW-1:0]        mode_i,
  input  logic signed [bss_pkg::DataW-1:0] value_i,
  input  logic                             cfg_we_i,
  input  logic [bss_pkg::CntW-1:0]         cfg_wdata_i,
  output logic                             done_o,
  output logic [bss_pkg::StatW-1:0]        status_o,
  output logic                             present_o,
  output logic [bss_pkg::CntW-1:0]         count_o
);

  localparam logic [bss_pkg::CntW-1:0] DepthCnt = bss_pkg::CntW'(bss_pkg::Depth);

  logic [bss_pkg::CntW-1:0]  cap_q, cap_d;
  logic [bss_pkg::CntW-1:0]  cap_eff;
  logic [bss_pkg::DataW-1:0] rdata;
  bss_pkg::mem_req_t         mem_req;
  logic                      accept;

  assign cap_d   = cfg_we_i ? cfg_wdata_i : cap_q;
  assign cap_eff = (cap_q > DepthCnt) ? DepthCnt : cap_q;
  assign accept  = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= DepthCnt;
    end else begin
      cap_q <= cap_d;
    end
  end

  bss_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  bss_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .mode_i    (mode_i),
    .value_i   (value_i),
    .cap_i     (cap_eff),
    .rdata_i   (rdata),
    .req_o     (mem_req),
    .busy_o    (busy),
    .done_o    (done_o),
    .status_o  (status_o),
    .present_o (present_o),
    .count_o   (count_o)
  );

endmodule

// ===== rtl/bss_store.sv =====
module bss_store (
  input  logic                         clk_i,
  input  bss_pkg::mem_req_t            req_i,
  output logic [bss_pkg::DataW-1:0]    rdata_o
);

  logic [bss_pkg::DataW-1:0] mem [bss_pkg::Depth];
  logic [bss_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bss_seq.sv =====
module bss_seq (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [bss_pkg::ModeW-1:0]           mode_i,
  input  logic [bss_pkg::DataW-1:0]           value_i,
  input  logic [bss_pkg::CntW-1:0]            cap_i,
  input  logic [bss_pkg::DataW-1:0]           rdata_i,
  output bss_pkg::mem_req_t                   req_o,
  output logic                                busy_o,
  output logic                                done_o,
  output logic [bss_pkg::StatW-1:0]           status_o,
  output logic                                present_o,
  output logic [bss_pkg::CntW-1:0]            count_o
);

  bss_pkg::state_e               state_q, state_d;
  logic [bss_pkg::AddrW-1:0]     idx_q, idx_d;
  logic [bss_pkg::CntW-1:0]      held_q, held_d;
  logic [bss_pkg::ModeW-1:0]     mode_q, mode_d;
  logic [bss_pkg::DataW-1:0]     value_q, value_d;
  logic                          found_q, found_d;
  logic                          done_q, done_d;
  bss_pkg::status_e              status_q, status_d;
  logic                          present_q, present_d;
  logic [bss_pkg::CntW-1:0]      count_q, count_d;

  logic                          hit;
  logic [bss_pkg::CntW-1:0]      idx_p1, idx_p2;
  logic                          room;

  // The one comparator: stored entry against the request value.
  assign hit    = (rdata_i == value_q);
  assign idx_p1 = {1'b0, idx_q} + bss_pkg::CntW'(1);
  assign idx_p2 = {1'b0, idx_q} + bss_pkg::CntW'(2);
  assign room   = (held_q < cap_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      bss_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = (held_q == '0) ? bss_pkg::S_FINISH : bss_pkg::S_SCAN;
        end
      end
      bss_pkg::S_SCAN: begin
        if (hit) begin
          if (mode_q == bss_pkg::MODE_REMOVE && idx_p1 < held_q) begin
            state_d = bss_pkg::S_SHIFT;
          end else begin
            state_d = bss_pkg::S_FINISH;
          end
        end else if (idx_p1 >= held_q) begin
          state_d = bss_pkg::S_FINISH;
        end
      end
      bss_pkg::S_SHIFT: begin
        if (idx_p2 >= held_q) begin
          state_d = bss_pkg::S_FINISH;
        end
      end
      bss_pkg::S_FINISH: state_d = bss_pkg::S_IDLE;
      default:           state_d = bss_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    held_d      = held_q;
    mode_d      = mode_q;
    value_d     = value_q;
    found_d     = found_q;
    done_d      = 1'b0;
    status_d    = status_q;
    present_d   = present_q;
    count_d     = count_q;
    req_o.we    = 1'b0;
    req_o.waddr = idx_q;
    req_o.wdata = rdata_i;
    req_o.raddr = idx_q;
    case (state_q)
      bss_pkg::S_IDLE: begin
        if (start_i) begin
          mode_d      = mode_i;
          value_d     = value_i;
          idx_d       = '0;
          found_d     = 1'b0;
          req_o.raddr = '0;
        end
      end
      bss_pkg::S_SCAN: begin
        // Read one slot ahead; on a hit in a remove this is the first entry to move down.
        req_o.raddr = idx_p1[bss_pkg::AddrW-1:0];
        if (hit) begin
          found_d = 1'b1;
        end else begin
          idx_d = idx_p1[bss_pkg::AddrW-1:0];
        end
      end
      bss_pkg::S_SHIFT: begin
        req_o.we    = 1'b1;
        req_o.waddr = idx_q;
        req_o.wdata = rdata_i;
        req_o.raddr = idx_p2[bss_pkg::AddrW-1:0];
        idx_d       = idx_p1[bss_pkg::AddrW-1:0];
      end
      bss_pkg::S_FINISH: begin
        done_d    = 1'b1;
        present_d = found_q;
        if (mode_q == bss_pkg::MODE_ADD) begin
          if (found_q) begin
            status_d = bss_pkg::STAT_DUP;
          end else if (room) begin
            status_d    = bss_pkg::STAT_ADDED;
            req_o.we    = 1'b1;
            req_o.waddr = held_q[bss_pkg::AddrW-1:0];
            req_o.wdata = value_q;
            held_d      = held_q + bss_pkg::CntW'(1);
          end else begin
            status_d = bss_pkg::STAT_FULL;
          end
        end else if (mode_q == bss_pkg::MODE_REMOVE) begin
          if (found_q) begin
            status_d = bss_pkg::STAT_REMOVED;
            held_d   = held_q - bss_pkg::CntW'(1);
          end else begin
            status_d = bss_pkg::STAT_ABSENT;
          end
        end else begin
          status_d = bss_pkg::STAT_QUERY;
        end
        count_d = held_d;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bss_pkg::S_IDLE;
      held_q  <= '0;
      done_q  <= 1'b0;
      found_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      done_q  <= done_d;
      found_q <= found_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    value_q   <= value_d;
    status_q  <= status_d;
    present_q <= present_d;
    count_q   <= count_d;
  end

  assign busy_o    = (state_q != bss_pkg::S_IDLE);
  assign done_o    = done_q;
  assign status_o  = status_q;
  assign present_o = present_q;
  assign count_o   = count_q;

`ifndef SYNTH
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= bss_pkg::CntW'(bss_pkg::Depth))
    else $error("held count exceeds storage depth");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for more than one cycle");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bss_pkg::S_SCAN) |-> ({1'b0, idx_q} < held_q))
    else $error("scan index past the held entries");

  a_shift_on_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bss_pkg::S_SHIFT) |-> (found_q && mode_q == bss_pkg::MODE_REMOVE))
    else $error("entries shifted without a matching remove");

  a_add_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bss_pkg::S_FINISH && status_d == bss_pkg::STAT_ADDED)
      |=> (count_o == $past(held_q) + bss_pkg::CntW'(1)))
    else $error("add did not grow the count by one");
`endif

endmodule
